// ===== hw/rtl/wpwf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and microprogram ROM for the windowed PID wall follower.
// No dependencies; imported by every module of the block.
package wpwf_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_SETPOINT       = 3'd0;
    localparam logic [2:0] CFG_P_GAIN         = 3'd1;
    localparam logic [2:0] CFG_I_GAIN         = 3'd2;
    localparam logic [2:0] CFG_D_GAIN         = 3'd3;
    localparam logic [2:0] CFG_DIVISOR        = 3'd4;
    localparam logic [2:0] CFG_DT             = 3'd5;
    localparam logic [2:0] CFG_WALL_THRESHOLD = 3'd6;
    localparam logic [2:0] CFG_BASE_SPEED     = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;

    // Register reset values
    localparam logic [7:0]  RST_SETPOINT   = 8'd80;
    localparam logic [7:0]  RST_P_GAIN     = 8'd80;
    localparam logic [7:0]  RST_I_GAIN     = 8'd20;
    localparam logic [7:0]  RST_D_GAIN     = 8'd200;
    localparam logic [7:0]  RST_DIVISOR    = 8'd100;
    localparam logic [7:0]  RST_DT         = 8'd1;
    localparam logic [11:0] RST_WALL_THR   = 12'd6;
    localparam logic [8:0]  RST_BASE_SPEED = 9'h096;

    // Correction clamp
    localparam logic signed [7:0] CORR_MAX = 8'sd127;
    localparam logic signed [7:0] CORR_MIN = -8'sd128;

    // Divider: quotient bits resolved per cycle, divisor width
    localparam int DIV_BITS_PER_CYCLE = 4;
    localparam int DIV_DEN_W          = 8;

    // Infrared beacon characters
    localparam logic [7:0] IR_RED         = 8'd248;
    localparam logic [7:0] IR_GREEN       = 8'd244;
    localparam logic [7:0] IR_RED_GREEN   = 8'd252;
    localparam logic [7:0] IR_RED_FORCE   = 8'd250;
    localparam logic [7:0] IR_GREEN_FORCE = 8'd246;
    localparam logic [7:0] IR_ALL         = 8'd254;

    typedef enum logic [2:0] {
        BC_NONE        = 3'd0,
        BC_RED         = 3'd1,
        BC_GREEN       = 3'd2,
        BC_RED_GREEN   = 3'd3,
        BC_RED_FORCE   = 3'd4,
        BC_GREEN_FORCE = 3'd5,
        BC_ALL         = 3'd6
    } t_beacon;

    typedef enum logic [1:0] {
        MODE_SEARCH = 2'd0,
        MODE_BUMPED = 2'd1,
        MODE_FOLLOW = 2'd2,
        MODE_DOCK   = 2'd3
    } t_mode;

    // Microcode fields
    typedef enum logic [2:0] {
        OP_NOP, OP_ERR, OP_SHIFT, OP_SAVE_IG, OP_SAT, OP_HALT, OP_OUT
    } t_op;

    typedef enum logic [1:0] {
        MA_ERR, MA_ESUM, MA_QUO, MA_IGAIN
    } t_mula;

    typedef enum logic [2:0] {
        MB_DEPTH, MB_PGAIN, MB_DT, MB_IGDT, MB_DGAIN
    } t_mulb;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_LOAD, ACC_ADD
    } t_acc;

    typedef enum logic [1:0] {
        DS_DIFF, DS_ACC
    } t_dsrc;

    typedef enum logic [2:0] {
        J_NEXT, J_WAIT_IN, J_HALT, J_DIV_BUSY, J_WAIT_OUT, J_GOTO
    } t_jc;

    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_IDLE = 5'd0;
    localparam t_step STEP_HALT = 5'd14;

    typedef struct packed {
        t_op   op;
        logic  mul_en;
        t_mula mula;
        t_mulb mulb;
        t_acc  acc;
        logic  div_go;
        t_dsrc dsrc;
        t_jc   jc;
        t_step target;
    } t_ctl;

    function automatic t_ctl mk_ctl(
        input t_op op, input logic mul_en, input t_mula mula, input t_mulb mulb,
        input t_acc acc, input logic div_go, input t_dsrc dsrc, input t_jc jc,
        input t_step target
    );
        t_ctl c;
        c.op     = op;
        c.mul_en = mul_en;
        c.mula   = mula;
        c.mulb   = mulb;
        c.acc    = acc;
        c.div_go = div_go;
        c.dsrc   = dsrc;
        c.jc     = jc;
        c.target = target;
        return c;
    endfunction

    // Microprogram: one control word per step
    function automatic t_ctl ucode(input t_step addr);
        t_ctl c;
        unique case (addr)
            // wait for a sample
            5'd0:  c = mk_ctl(OP_NOP, 1'b0, MA_ERR, MB_DEPTH, ACC_HOLD, 1'b0, DS_DIFF,
                              J_WAIT_IN, STEP_IDLE);
            // form the error, branch off when halted
            5'd1:  c = mk_ctl(OP_ERR, 1'b0, MA_ERR, MB_DEPTH, ACC_HOLD, 1'b0, DS_DIFF,
                              J_HALT, STEP_HALT);
            // depth * error for priming
            5'd2:  c = mk_ctl(OP_NOP, 1'b1, MA_ERR, MB_DEPTH, ACC_HOLD, 1'b0, DS_DIFF,
                              J_NEXT, STEP_IDLE);
            // shift windows; i_gain * dt
            5'd3:  c = mk_ctl(OP_SHIFT, 1'b1, MA_IGAIN, MB_DT, ACC_HOLD, 1'b0, DS_DIFF,
                              J_NEXT, STEP_IDLE);
            // keep i_gain*dt; P term; start difference / dt
            5'd4:  c = mk_ctl(OP_SAVE_IG, 1'b1, MA_ERR, MB_PGAIN, ACC_HOLD, 1'b1, DS_DIFF,
                              J_NEXT, STEP_IDLE);
            // acc = P; I term
            5'd5:  c = mk_ctl(OP_NOP, 1'b1, MA_ESUM, MB_IGDT, ACC_LOAD, 1'b0, DS_DIFF,
                              J_NEXT, STEP_IDLE);
            // acc += I
            5'd6:  c = mk_ctl(OP_NOP, 1'b0, MA_ERR, MB_DEPTH, ACC_ADD, 1'b0, DS_DIFF,
                              J_NEXT, STEP_IDLE);
            5'd7:  c = mk_ctl(OP_NOP, 1'b0, MA_ERR, MB_DEPTH, ACC_HOLD, 1'b0, DS_DIFF,
                              J_DIV_BUSY, STEP_IDLE);
            // D term
            5'd8:  c = mk_ctl(OP_NOP, 1'b1, MA_QUO, MB_DGAIN, ACC_HOLD, 1'b0, DS_DIFF,
                              J_NEXT, STEP_IDLE);
            5'd9:  c = mk_ctl(OP_NOP, 1'b0, MA_ERR, MB_DEPTH, ACC_ADD, 1'b0, DS_DIFF,
                              J_NEXT, STEP_IDLE);
            // sum / divisor
            5'd10: c = mk_ctl(OP_NOP, 1'b0, MA_ERR, MB_DEPTH, ACC_HOLD, 1'b1, DS_ACC,
                              J_NEXT, STEP_IDLE);
            5'd11: c = mk_ctl(OP_NOP, 1'b0, MA_ERR, MB_DEPTH, ACC_HOLD, 1'b0, DS_ACC,
                              J_DIV_BUSY, STEP_IDLE);
            // clamp
            5'd12: c = mk_ctl(OP_SAT, 1'b0, MA_ERR, MB_DEPTH, ACC_HOLD, 1'b0, DS_ACC,
                              J_NEXT, STEP_IDLE);
            5'd13: c = mk_ctl(OP_OUT, 1'b0, MA_ERR, MB_DEPTH, ACC_HOLD, 1'b0, DS_ACC,
                              J_WAIT_OUT, STEP_IDLE);
            // halted: hold the windows, clear the drive
            5'd14: c = mk_ctl(OP_HALT, 1'b0, MA_ERR, MB_DEPTH, ACC_HOLD, 1'b0, DS_DIFF,
                              J_NEXT, STEP_IDLE);
            5'd15: c = mk_ctl(OP_OUT, 1'b0, MA_ERR, MB_DEPTH, ACC_HOLD, 1'b0, DS_DIFF,
                              J_WAIT_OUT, STEP_IDLE);
            default: c = mk_ctl(OP_NOP, 1'b0, MA_ERR, MB_DEPTH, ACC_HOLD, 1'b0, DS_DIFF,
                                J_GOTO, STEP_IDLE);
        endcase
        return c;
    endfunction

    function automatic t_beacon beacon_decode(input logic [7:0] b);
        t_beacon r;
        unique case (b)
            IR_RED:         r = BC_RED;
            IR_GREEN:       r = BC_GREEN;
            IR_RED_GREEN:   r = BC_RED_GREEN;
            IR_RED_FORCE:   r = BC_RED_FORCE;
            IR_GREEN_FORCE: r = BC_GREEN_FORCE;
            IR_ALL:         r = BC_ALL;
            default:        r = BC_NONE;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/windowed_pid_wall_follower.sv =====
`timescale 1ns / 1ps
// Windowed PID wall follower: microcoded sequencer, datapath and windows.
// Uses wpwf_pkg and the iterative divider wpwf_divider.
//
// Usage
//   Input channel (i_in_valid / o_in_ready) takes one sensor sample per
//   transfer: wall reading, bump/drop bits, IR character, charger flag.
//   Output channel (o_out_valid / i_out_ready) returns one result per sample:
//   saturated correction, both wheel speeds, ten-sample wall average, mode,
//   decoded beacon and the halted flag.
//   Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_wdata);
//   write it only while no sample is in flight.
// Timing
//   One sample at a time. A sample passes through the sequencer steps in
//   order and waits twice on the shared divider (difference/dt, PID
//   sum/divisor), which works on UW = WALL_BITS + clog2(WINDOW_DEPTH) + 19
//   bits, 35 at the defaults. The wall average is a reciprocal multiply of
//   the running wall sum. A halted sample branches from the error step to
//   the halt and output steps. The next sample is taken as soon as the
//   sequencer returns to idle.
// Reset and stall
//   Synchronous active-low reset loads the register defaults, clears both
//   windows, the priming, dock and halt flags and drops any pending result.
//   A result waits in the output register while the receiver stalls; the
//   next sample is still taken and computed, then holds at its output step
//   until the slot frees.
module windowed_pid_wall_follower
    import wpwf_pkg::*;
#(
    parameter int WINDOW_DEPTH = 10,
    parameter int WALL_BITS    = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // sample channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [WALL_BITS-1:0]     i_wall_signal,
    input  logic [4:0]               i_bump_drop,
    input  logic [7:0]               i_ir_byte,
    input  logic                     i_charger_seen,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [7:0]        o_correction,
    output logic signed [10:0]       o_right_speed,
    output logic signed [10:0]       o_left_speed,
    output logic [WALL_BITS-1:0]     o_wall_average,
    output logic [1:0]               o_mode,
    output logic [2:0]               o_beacon,
    output logic                     o_halted,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_wdata
);

    // Datapath widths
    localparam int EW  = WALL_BITS + 1;                  // error
    localparam int SW  = EW + $clog2(WINDOW_DEPTH);      // error window sum
    localparam int MA  = SW;                             // multiplier signed operand
    localparam int PW  = SW + 17;                        // product
    localparam int UW  = SW + 18;                        // PID accumulator / divider
    localparam int WSW = WALL_BITS + $clog2(WINDOW_DEPTH);

    // Wall average: floor(sum / depth) as (sum * ceil(2^AVG_SH / depth)) >> AVG_SH,
    // exact for every sum below 2^WSW
    localparam int AVG_SH = WSW + $clog2(WINDOW_DEPTH);
    localparam int AVG_RW = WSW + 1;
    localparam int AVG_PW = WSW + AVG_RW;
    localparam logic [AVG_RW-1:0] AVG_RECIP =
        AVG_RW'(((64'd1 << AVG_SH) + 64'(WINDOW_DEPTH - 1)) / 64'(WINDOW_DEPTH));

    localparam logic signed [UW-1:0] SAT_HI = UW'(CORR_MAX);
    localparam logic signed [UW-1:0] SAT_LO = UW'(CORR_MIN);

    // Configuration registers
    logic [7:0]  r_setpoint, r_p_gain, r_i_gain, r_d_gain, r_divisor, r_dt;
    logic [11:0] r_wall_thr;
    logic [8:0]  r_base;

    // Sequencer
    t_step r_step, n_step;
    t_ctl  w_ctl;

    // Captured sample
    logic [WALL_BITS-1:0] r_wall;
    logic [4:0]           r_bump;
    t_beacon              r_beacon;
    logic                 r_charger;

    // State
    logic signed [EW-1:0]  r_ewin [WINDOW_DEPTH];
    logic [WALL_BITS-1:0]  r_wwin [WINDOW_DEPTH];
    logic signed [SW-1:0]  r_esum;
    logic [WSW-1:0]        r_wsum;
    logic                  r_primed, r_dock, r_halt;

    // Working registers
    logic signed [EW-1:0]  r_err, r_prev;
    logic signed [PW-1:0]  r_prod;
    logic signed [UW-1:0]  r_acc;
    logic [15:0]           r_igdt;
    logic signed [7:0]     r_corr;
    t_mode                 r_mode;

    // Output register
    logic                  r_out_valid;
    logic signed [7:0]     r_o_corr;
    logic signed [10:0]    r_o_right, r_o_left;
    logic [WALL_BITS-1:0]  r_o_avg;
    t_mode                 r_o_mode;
    t_beacon               r_o_beacon;
    logic                  r_o_halted;

    logic                  w_in_xfer, w_slot_free, w_halting;
    logic [7:0]            w_dtv, w_divv;
    logic signed [EW-1:0]  w_err;
    logic signed [EW:0]    w_diff;
    logic signed [MA-1:0]  w_mul_a;
    logic [15:0]           w_mul_b;
    logic signed [PW-1:0]  w_prod;
    logic signed [UW-1:0]  w_div_num;
    logic [7:0]            w_div_den;
    logic                  w_div_busy;
    logic signed [UW-1:0]  w_quo;
    logic [AVG_PW-1:0]     w_avg_prod;
    logic                  w_bump_clear, w_at_wall, w_dock_next;
    t_mode                 w_mode;
    logic signed [10:0]    w_right, w_left;

    assign w_ctl       = ucode(r_step);
    assign o_in_ready  = (w_ctl.jc == J_WAIT_IN);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_halting   = r_charger || r_halt;

    // Zero dt or divisor behaves as one
    assign w_dtv  = (r_dt == 8'd0) ? 8'd1 : r_dt;
    assign w_divv = (r_divisor == 8'd0) ? 8'd1 : r_divisor;

    assign w_err  = $signed(EW'(r_setpoint)) - $signed(EW'(r_wall));
    assign w_diff = {r_err[EW-1], r_err} - {r_prev[EW-1], r_prev};

    // ---------------------------------------------------------------
    // Configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= RST_SETPOINT;
            r_p_gain   <= RST_P_GAIN;
            r_i_gain   <= RST_I_GAIN;
            r_d_gain   <= RST_D_GAIN;
            r_divisor  <= RST_DIVISOR;
            r_dt       <= RST_DT;
            r_wall_thr <= RST_WALL_THR;
            r_base     <= RST_BASE_SPEED;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SETPOINT:       r_setpoint <= i_cfg_wdata[7:0];
                CFG_P_GAIN:         r_p_gain   <= i_cfg_wdata[7:0];
                CFG_I_GAIN:         r_i_gain   <= i_cfg_wdata[7:0];
                CFG_D_GAIN:         r_d_gain   <= i_cfg_wdata[7:0];
                CFG_DIVISOR:        r_divisor  <= i_cfg_wdata[7:0];
                CFG_DT:             r_dt       <= i_cfg_wdata[7:0];
                CFG_WALL_THRESHOLD: r_wall_thr <= i_cfg_wdata;
                CFG_BASE_SPEED:     r_base     <= i_cfg_wdata[8:0];
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Step counter and conditional jumps
    // ---------------------------------------------------------------
    always_comb begin
        n_step = r_step;
        unique case (w_ctl.jc)
            J_NEXT:     n_step = r_step + t_step'(1);
            J_WAIT_IN:  if (w_in_xfer) n_step = r_step + t_step'(1);
            J_HALT:     n_step = w_halting ? w_ctl.target : r_step + t_step'(1);
            J_DIV_BUSY: if (!w_div_busy) n_step = r_step + t_step'(1);
            J_WAIT_OUT: if (w_slot_free) n_step = w_ctl.target;
            J_GOTO:     n_step = w_ctl.target;
            default:    n_step = STEP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // ---------------------------------------------------------------
    // Shared multiplier: signed operand times unsigned 16-bit operand
    // ---------------------------------------------------------------
    always_comb begin
        unique case (w_ctl.mula)
            MA_ERR:   w_mul_a = MA'(r_err);
            MA_ESUM:  w_mul_a = r_esum;
            MA_QUO:   w_mul_a = w_quo[MA-1:0];
            MA_IGAIN: w_mul_a = MA'(r_i_gain);
            default:  w_mul_a = '0;
        endcase
    end

    always_comb begin
        unique case (w_ctl.mulb)
            MB_DEPTH: w_mul_b = 16'(WINDOW_DEPTH);
            MB_PGAIN: w_mul_b = 16'(r_p_gain);
            MB_DT:    w_mul_b = 16'(w_dtv);
            MB_IGDT:  w_mul_b = r_igdt;
            MB_DGAIN: w_mul_b = 16'(r_d_gain);
            default:  w_mul_b = '0;
        endcase
    end

    assign w_prod = PW'(w_mul_a) * PW'($signed({1'b0, w_mul_b}));

    // ---------------------------------------------------------------
    // Divider operands
    // ---------------------------------------------------------------
    always_comb begin
        unique case (w_ctl.dsrc)
            DS_DIFF: begin
                w_div_num = UW'(w_diff);
                w_div_den = w_dtv;
            end
            DS_ACC: begin
                w_div_num = r_acc;
                w_div_den = w_divv;
            end
            default: begin
                w_div_num = '0;
                w_div_den = 8'd1;
            end
        endcase
    end

    wpwf_divider #(
        .NW(UW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctl.div_go),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo)
    );

    // Wall average from the running sum
    assign w_avg_prod = AVG_PW'(r_wsum) * AVG_PW'(AVG_RECIP);

    // ---------------------------------------------------------------
    // Mode decision (contact wins over wall, dock needs a beacon)
    // ---------------------------------------------------------------
    assign w_bump_clear = (r_bump == 5'd0);
    assign w_at_wall    = 16'(r_wall) >= 16'(r_wall_thr);
    assign w_dock_next  = r_dock || (w_bump_clear && w_at_wall);

    always_comb begin
        priority if (r_beacon != BC_NONE && w_dock_next) begin
            w_mode = MODE_DOCK;
        end else if (w_bump_clear && w_at_wall) begin
            w_mode = MODE_FOLLOW;
        end else if (w_bump_clear) begin
            w_mode = MODE_SEARCH;
        end else begin
            w_mode = MODE_BUMPED;
        end
    end

    // ---------------------------------------------------------------
    // Windows and latched flags
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                r_ewin[i] <= '0;
                r_wwin[i] <= '0;
            end
            r_esum   <= '0;
            r_wsum   <= '0;
            r_primed <= 1'b0;
            r_dock   <= 1'b0;
            r_halt   <= 1'b0;
        end else begin
            unique case (w_ctl.op)
                OP_SHIFT: begin
                    // First sample fills the whole error window with its error
                    for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
                        r_ewin[i] <= r_primed ? r_ewin[i+1] : r_err;
                        r_wwin[i] <= r_wwin[i+1];
                    end
                    r_ewin[WINDOW_DEPTH-1] <= r_err;
                    r_wwin[WINDOW_DEPTH-1] <= r_wall;
                    // Running sums: drop the oldest, add the newest
                    r_esum <= r_primed ? (r_esum - SW'(r_ewin[0]) + SW'(r_err))
                                       : r_prod[SW-1:0];
                    r_wsum <= r_wsum - WSW'(r_wwin[0]) + WSW'(r_wall);
                    r_primed <= 1'b1;
                    r_dock   <= w_dock_next;
                end
                OP_HALT: r_halt <= 1'b1;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sample capture and working registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_wall    <= i_wall_signal;
            r_bump    <= i_bump_drop;
            r_beacon  <= beacon_decode(i_ir_byte);
            r_charger <= i_charger_seen;
        end
        if (w_ctl.mul_en) begin
            r_prod <= w_prod;
        end
        unique case (w_ctl.acc)
            ACC_LOAD: r_acc <= UW'(r_prod);
            ACC_ADD:  r_acc <= r_acc + UW'(r_prod);
            default:  ;
        endcase
        unique case (w_ctl.op)
            OP_ERR:     r_err <= w_err;
            OP_SHIFT: begin
                // newest error before this one, or this one on the first sample
                r_prev <= r_primed ? r_ewin[WINDOW_DEPTH-1] : r_err;
                r_mode <= w_mode;
            end
            OP_SAVE_IG: r_igdt <= r_prod[15:0];
            OP_SAT: begin
                if (w_quo > SAT_HI) begin
                    r_corr <= CORR_MAX;
                end else if (w_quo < SAT_LO) begin
                    r_corr <= CORR_MIN;
                end else begin
                    r_corr <= w_quo[7:0];
                end
            end
            OP_HALT: begin
                r_corr <= '0;
                r_mode <= MODE_SEARCH;
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    assign w_right = $signed({2'b00, r_base}) + 11'(r_corr);
    assign w_left  = $signed({2'b00, r_base}) - 11'(r_corr);

    always_ff @(posedge i_clk) begin
        if (w_ctl.op == OP_OUT && w_slot_free) begin
            r_o_corr   <= r_corr;
            r_o_right  <= r_halt ? 11'sd0 : w_right;
            r_o_left   <= r_halt ? 11'sd0 : w_left;
            r_o_avg    <= w_avg_prod[AVG_SH +: WALL_BITS];
            r_o_mode   <= r_mode;
            r_o_beacon <= r_beacon;
            r_o_halted <= r_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.op == OP_OUT && w_slot_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_correction   = r_o_corr;
    assign o_right_speed  = r_o_right;
    assign o_left_speed   = r_o_left;
    assign o_wall_average = r_o_avg;
    assign o_mode         = r_o_mode;
    assign o_beacon       = r_o_beacon;
    assign o_halted       = r_o_halted;

endmodule

// ===== hw/rtl/wpwf_divider.sv =====
`timescale 1ns / 1ps
// Iterative signed-by-unsigned divider, truncating toward zero.
// Resolves DIV_BITS_PER_CYCLE quotient bits per cycle; uses wpwf_pkg.
module wpwf_divider
    import wpwf_pkg::*;
#(
    parameter int NW = 36
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NW-1:0]    i_num,
    input  logic [DIV_DEN_W-1:0]    i_den,
    output logic                    o_busy,
    output logic signed [NW-1:0]    o_quo
);

    localparam int R     = DIV_BITS_PER_CYCLE;
    localparam int STEPS = (NW + R - 1) / R;
    localparam int PADW  = STEPS * R;
    localparam int CW    = $clog2(STEPS + 1);

    logic                  r_busy;
    logic [CW-1:0]         r_cnt;
    logic [DIV_DEN_W-1:0]  r_rem;
    logic [DIV_DEN_W-1:0]  r_den;
    logic [PADW-1:0]       r_num;
    logic                  r_neg;

    logic [NW-1:0]         w_mag;
    logic [DIV_DEN_W-1:0]  w_rem_next;
    logic [PADW-1:0]       w_num_next;

    assign w_mag = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);

    // R restoring steps: shift a dividend bit into the remainder, subtract if it fits
    always_comb begin
        logic [DIV_DEN_W:0]   v_rem9;
        logic [DIV_DEN_W-1:0] v_rem;
        logic [PADW-1:0]      v_num;
        v_rem = r_rem;
        v_num = r_num;
        for (int k = 0; k < R; k++) begin
            v_rem9 = {v_rem, v_num[PADW-1]};
            v_num  = {v_num[PADW-2:0], 1'b0};
            if (v_rem9 >= {1'b0, r_den}) begin
                v_rem9   = v_rem9 - {1'b0, r_den};
                v_num[0] = 1'b1;
            end
            v_rem = v_rem9[DIV_DEN_W-1:0];
        end
        w_rem_next = v_rem;
        w_num_next = v_num;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= PADW'(w_mag);
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[NW-1];
        end else if (r_busy) begin
            r_num <= w_num_next;
            r_rem <= w_rem_next;
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_neg ? -$signed(r_num[NW-1:0]) : $signed(r_num[NW-1:0]);

endmodule

// ===== hw/rtl/wpwf_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for windowed_pid_wall_follower, attached by bind.
// Uses wpwf_pkg for mode and beacon codes.
module wpwf_checker
    import wpwf_pkg::*;
#(
    parameter int WALL_BITS = 12
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic signed [7:0]     o_correction,
    input logic signed [10:0]    o_right_speed,
    input logic signed [10:0]    o_left_speed,
    input logic [WALL_BITS-1:0]  o_wall_average,
    input logic [1:0]            o_mode,
    input logic [2:0]            o_beacon,
    input logic                  o_halted
);

    logic signed [11:0] w_spread, w_twice;

    assign w_spread = 12'(o_right_speed) - 12'(o_left_speed);
    assign w_twice  = {12'(o_correction)} <<< 1;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_correction) && $stable(o_right_speed) && $stable(o_left_speed) &&
            $stable(o_wall_average) && $stable(o_mode) && $stable(o_beacon) &&
            $stable(o_halted))
        else $error("result changed while stalled");

    a_halt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_halted |->
            o_correction == 8'sd0 && o_right_speed == 11'sd0 &&
            o_left_speed == 11'sd0 && o_mode == MODE_SEARCH)
        else $error("halted result carries drive");

    a_speed_spread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_halted |-> w_spread == w_twice)
        else $error("wheel speeds disagree with correction");

    a_dock_beacon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mode == MODE_DOCK |-> o_beacon != BC_NONE)
        else $error("dock mode without beacon");

endmodule

bind windowed_pid_wall_follower wpwf_checker #(
    .WALL_BITS(WALL_BITS)
) u_wpwf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_correction   (o_correction),
    .o_right_speed  (o_right_speed),
    .o_left_speed   (o_left_speed),
    .o_wall_average (o_wall_average),
    .o_mode         (o_mode),
    .o_beacon       (o_beacon),
    .o_halted       (o_halted)
);
